// ===== rtl/bwd_pkg.sv =====
`timescale 1ns / 1ps

package bwd_pkg;

  localparam int NUM_WINDOWS = 4;
  localparam int MAX_WINDOWS = 4;
  localparam int WIN_IDX_W   = 2;
  localparam int CFG_IDX_W   = 3;

  // Width codes of an access or sub-access.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Low bit of a configuration index picks base or limit of a window.
  localparam logic CFG_SEL_BASE  = 1'b0;
  localparam logic CFG_SEL_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SELECT,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic load;    // capture an accepted access
    logic lookup;  // register the window hit vector of the current range
    logic select;  // register the lowest-base hit
    logic emit;    // load the result register and move to the next range
    logic split;   // replace the current range by its low half
  } ctrl_cmd_t;

  typedef struct packed {
    logic found;      // some window holds the whole current range
    logic size_zero;  // the current range is a single byte
    logic out_free;   // the result register can take a beat this cycle
    logic last;       // the current range ends the access
  } dp_status_t;

endpackage

// ===== rtl/bus_window_decoder_with_splitting.sv =====
`timescale 1ns / 1ps

// Decodes one bus access (byte, halfword or word) against four address
// windows, each given by an inclusive base and limit, and emits one to four
// sub-accesses. Word accesses are aligned down to 4 and halfwords down to 2.
// When no window holds the whole access it is split into halves, low half
// first, down to single bytes; a byte that no window holds comes out flagged
// unmapped with window 0 and offset 0. Where windows overlap, the lowest base
// wins, then the lowest index. Each range tried passes through the lookup,
// select and decide states of the shared window compare and select unit,
// after the idle state accepts the access; a word split fully into bytes
// tries seven ranges, and a stall on the result side holds the decide state.
// The result register lets the next access be accepted while the final beat
// still waits. The user must write window registers through the cfg port
// only while no access is in flight; the block does not enforce this. The port is always ready.
module bus_window_decoder_with_splitting (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [1:0]                     in_access_size,
  input  logic [31:0]                    in_bus_address,
  input  logic [31:0]                    in_write_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bwd_pkg::WIN_IDX_W-1:0]  out_window_index,
  output logic [31:0]                    out_offset,
  output logic [1:0]                     out_sub_size,
  output logic [1:0]                     out_byte_lane,
  output logic [31:0]                    out_sub_write_data,
  output logic                           out_is_write,
  output logic                           out_unmapped,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import bwd_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  bwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  bwd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (ctrl_cmd),
    .status_o           (dp_status),
    .in_cmd             (in_cmd),
    .in_access_size     (in_access_size),
    .in_bus_address     (in_bus_address),
    .in_write_data      (in_write_data),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_window_index   (out_window_index),
    .out_offset         (out_offset),
    .out_sub_size       (out_sub_size),
    .out_byte_lane      (out_byte_lane),
    .out_sub_write_data (out_sub_write_data),
    .out_is_write       (out_is_write),
    .out_unmapped       (out_unmapped),
    .out_last           (out_last)
  );

endmodule

// ===== rtl/bwd_ctrl.sv =====
`timescale 1ns / 1ps

module bwd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwd_pkg::dp_status_t status_i,
  output bwd_pkg::ctrl_cmd_t  cmd_o
);
  import bwd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: state_nxt = S_SELECT;
      S_SELECT: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (status_i.found || status_i.size_zero) begin
          if (status_i.out_free) begin
            state_nxt = status_i.last ? S_IDLE : S_LOOKUP;
          end
        end else begin
          state_nxt = S_LOOKUP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd_o    = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      S_LOOKUP: cmd_o.lookup = 1'b1;
      S_SELECT: cmd_o.select = 1'b1;
      S_DECIDE: begin
        if (status_i.found || status_i.size_zero) begin
          cmd_o.emit = status_i.out_free;
        end else begin
          cmd_o.split = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/bwd_dp.sv =====
`timescale 1ns / 1ps

module bwd_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bwd_pkg::ctrl_cmd_t             cmd_i,
  output bwd_pkg::dp_status_t            status_o,
  input  logic                           in_cmd,
  input  logic [1:0]                     in_access_size,
  input  logic [31:0]                    in_bus_address,
  input  logic [31:0]                    in_write_data,
  input  logic                           cfg_valid,
  input  logic [bwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bwd_pkg::WIN_IDX_W-1:0]  out_window_index,
  output logic [31:0]                    out_offset,
  output logic [1:0]                     out_sub_size,
  output logic [1:0]                     out_byte_lane,
  output logic [31:0]                    out_sub_write_data,
  output logic                           out_is_write,
  output logic                           out_unmapped,
  output logic                           out_last
);
  import bwd_pkg::*;

  logic [31:0] win_base_r  [MAX_WINDOWS];
  logic [31:0] win_limit_r [MAX_WINDOWS];

  logic                 is_write_r;
  logic [1:0]           tot_size_r;
  logic [31:0]          addr_r;
  logic [31:0]          data_r;
  logic [1:0]           lane_r;
  logic [1:0]           cur_size_r;
  logic [NUM_WINDOWS-1:0] hit_r;
  logic                 found_r;
  logic [WIN_IDX_W-1:0] best_r;

  logic                 out_valid_r;
  logic [WIN_IDX_W-1:0] out_window_index_r;
  logic [31:0]          out_offset_r;
  logic [1:0]           out_sub_size_r;
  logic [1:0]           out_byte_lane_r;
  logic [31:0]          out_sub_write_data_r;
  logic                 out_is_write_r;
  logic                 out_unmapped_r;
  logic                 out_last_r;

  logic [1:0]           in_size;
  logic [31:0]          in_addr_aligned;
  logic [31:0]          cur_lo;
  logic [31:0]          cur_hi;
  logic [1:0]           size_mask;
  logic [2:0]           lane_end;
  logic [2:0]           tot_bytes;
  logic                 out_free;
  logic [NUM_WINDOWS-1:0] hit_nxt;
  logic                 found_nxt;
  logic [WIN_IDX_W-1:0] best_nxt;
  logic [31:0]          data_slice;
  logic [31:0]          data_mask;

  // Size code three is taken as a word access.
  always_comb begin
    case (in_access_size)
      SZ_BYTE: begin
        in_size         = SZ_BYTE;
        in_addr_aligned = in_bus_address;
      end
      SZ_HALF: begin
        in_size         = SZ_HALF;
        in_addr_aligned = {in_bus_address[31:1], 1'b0};
      end
      default: begin
        in_size         = SZ_WORD;
        in_addr_aligned = {in_bus_address[31:2], 2'b00};
      end
    endcase
  end

  // Every range tried is aligned to its own size, so OR forms its bounds.
  always_comb begin
    case (cur_size_r)
      SZ_BYTE: size_mask = 2'b00;
      SZ_HALF: size_mask = 2'b01;
      default: size_mask = 2'b11;
    endcase
  end

  assign cur_lo    = {addr_r[31:2], addr_r[1:0] | lane_r};
  assign cur_hi    = {cur_lo[31:2], cur_lo[1:0] | size_mask};
  assign lane_end  = {1'b0, lane_r} + {1'b0, size_mask} + 3'd1;
  assign tot_bytes = 3'd1 << tot_size_r;
  assign out_free  = !out_valid_r || out_ready;

  // Since lo <= hi, lo >= base and hi <= limit already give containment.
  always_comb begin
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      hit_nxt[w] = (cur_lo >= win_base_r[w]) && (cur_hi <= win_limit_r[w]);
    end
  end

  always_comb begin
    found_nxt = 1'b0;
    best_nxt  = '0;
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      if (hit_r[w] && (!found_nxt || (win_base_r[w] < win_base_r[best_nxt]))) begin
        found_nxt = 1'b1;
        best_nxt  = WIN_IDX_W'(w);
      end
    end
  end

  always_comb begin
    case (cur_size_r)
      SZ_BYTE: data_mask = 32'h0000_00FF;
      SZ_HALF: data_mask = 32'h0000_FFFF;
      default: data_mask = 32'hFFFF_FFFF;
    endcase
    data_slice = (data_r >> {lane_r, 3'b000}) & data_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < MAX_WINDOWS; w++) begin
        win_base_r[w]  <= '0;
        win_limit_r[w] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index[0] == CFG_SEL_LIMIT) begin
        win_limit_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
      end else begin
        win_base_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      is_write_r <= in_cmd;
      tot_size_r <= in_size;
      cur_size_r <= in_size;
      addr_r     <= in_addr_aligned;
      data_r     <= in_write_data;
      lane_r     <= 2'd0;
    end else if (cmd_i.split) begin
      cur_size_r <= cur_size_r - 2'd1;
    end else if (cmd_i.emit) begin
      lane_r     <= lane_end[1:0];
      // The next range is a byte at an odd lane and a halfword at lane two.
      cur_size_r <= lane_end[0] ? SZ_BYTE : SZ_HALF;
    end
    if (cmd_i.lookup) begin
      hit_r <= hit_nxt;
    end
    if (cmd_i.select) begin
      found_r <= found_nxt;
      best_r  <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_window_index_r   <= found_r ? best_r : '0;
      out_offset_r         <= found_r ? (cur_lo - win_base_r[best_r]) : 32'd0;
      out_sub_size_r       <= cur_size_r;
      out_byte_lane_r      <= lane_r;
      out_sub_write_data_r <= (is_write_r == CMD_WRITE) ? data_slice : 32'd0;
      out_is_write_r       <= is_write_r;
      out_unmapped_r       <= !found_r;
      out_last_r           <= (lane_end == tot_bytes);
    end
  end

  assign status_o.found     = found_r;
  assign status_o.size_zero = (cur_size_r == SZ_BYTE);
  assign status_o.out_free  = out_free;
  assign status_o.last      = (lane_end == tot_bytes);

  assign out_valid          = out_valid_r;
  assign out_window_index   = out_window_index_r;
  assign out_offset         = out_offset_r;
  assign out_sub_size       = out_sub_size_r;
  assign out_byte_lane      = out_byte_lane_r;
  assign out_sub_write_data = out_sub_write_data_r;
  assign out_is_write       = out_is_write_r;
  assign out_unmapped       = out_unmapped_r;
  assign out_last           = out_last_r;

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded while the previous beat is still held");

  a_split_not_byte: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.split |-> (cur_size_r != SZ_BYTE))
    else $error("a single byte was split");

  a_unmapped_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unmapped) |-> (out_sub_size == SZ_BYTE && out_offset == 32'd0))
    else $error("unmapped beat that is not a plain byte");

  a_emit_hit_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit && found_r) |-> hit_r[best_r])
    else $error("chosen window did not hit");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bwd_pkg::*;

  localparam int RESET_CYCLES       = 6;
  localparam int NUM_PHASES         = 8;
  localparam int ACCESSES_PER_PHASE = 46;
  localparam int DRAIN_CYCLES       = 40;
  localparam int HOLD_CYCLES        = 200;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int REPORT_LIMIT       = 10;
  localparam int NUM_DIRECTED       = 32;

  // The unused width code; the block treats it as a word.
  localparam logic [1:0] SZ_WORD_ALIAS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WIN0_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN0_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN1_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN1_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN2_BASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN2_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIN3_BASE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WIN3_LIMIT = 3'd7;

  typedef struct packed {
    logic [WIN_IDX_W-1:0] win;
    logic [31:0]          offset;
    logic [1:0]           size;
    logic [1:0]           lane;
    logic [31:0]          wdata;
    logic                 wr;
    logic                 unm;
    logic                 last;
  } sub_access_t;

  typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_t;

  typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic                   cmd;
    logic [1:0]             size;
    logic [31:0]            addr;
    logic [31:0]            data;
    logic                   typed;
    sub_access_t            want;
  } dir_row_t;

  localparam sub_access_t NO_EXP = '0;

  // Register rows carry the write value in the data column.
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // After reset every window holds byte 0 alone.
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_READ, SZ_BYTE, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{2'd0, 32'h0, SZ_BYTE, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{2'd0, 32'h0, SZ_BYTE, 2'd0, 32'h0000_00FF, 1'b1, 1'b1, 1'b1}},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_HALF, 32'h0000_0001, 32'h1234_ABCD, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_READ, SZ_WORD_ALIAS, 32'h0000_0003, 32'hFFFF_FFFF, 1'b0,
      NO_EXP},
    // Overlapping windows, a two-byte window off word alignment, one at the top.
    '{ROW_REG, REG_WIN0_BASE,  CMD_READ, SZ_BYTE, 32'h0, 32'h0000_1000, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN0_LIMIT, CMD_READ, SZ_BYTE, 32'h0, 32'h0000_1FFF, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN1_BASE,  CMD_READ, SZ_BYTE, 32'h0, 32'h0000_0800, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN1_LIMIT, CMD_READ, SZ_BYTE, 32'h0, 32'h0000_17FF, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN2_BASE,  CMD_READ, SZ_BYTE, 32'h0, 32'h0000_3001, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN2_LIMIT, CMD_READ, SZ_BYTE, 32'h0, 32'h0000_3002, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN3_BASE,  CMD_READ, SZ_BYTE, 32'h0, 32'hFFFF_FFFE, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN3_LIMIT, CMD_READ, SZ_BYTE, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD, 32'h0000_1000, 32'hDEAD_BEEF, 1'b1,
      '{2'd1, 32'h0000_0800, SZ_WORD, 2'd0, 32'hDEAD_BEEF, 1'b1, 1'b0, 1'b1}},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_READ, SZ_WORD, 32'h0000_1802, 32'h5555_AAAA, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD, 32'h0000_17FE, 32'h0000_0000, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_READ, SZ_HALF, 32'h0000_1FFF, 32'h0000_0000, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD, 32'h0000_1FFE, 32'hFFFF_FFFF, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD, 32'h0000_2000, 32'h1122_3344, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD, 32'h0000_3000, 32'hCAFE_F00D, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_READ, SZ_HALF, 32'h0000_3000, 32'h0000_0000, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_BYTE, 32'h0000_3002, 32'h0000_00A5, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_READ, SZ_WORD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_HALF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{2'd3, 32'h0, SZ_HALF, 2'd0, 32'h0000_FFFF, 1'b1, 1'b0, 1'b1}},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_BYTE, 32'h0000_17FF, 32'h0000_005A, 1'b0, NO_EXP},
    // Window 3 with its limit below its base holds nothing.
    '{ROW_REG, REG_WIN3_BASE,  CMD_READ, SZ_BYTE, 32'h0, 32'h0000_4000, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN3_LIMIT, CMD_READ, SZ_BYTE, 32'h0, 32'h0000_3FFF, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_READ, SZ_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{2'd0, 32'h0, SZ_BYTE, 2'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1}},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD, 32'h0000_4000, 32'h89AB_CDEF, 1'b0, NO_EXP},
    // Window 2 spans everything and has the lowest base.
    '{ROW_REG, REG_WIN2_BASE,  CMD_READ, SZ_BYTE, 32'h0, 32'h0000_0000, 1'b0, NO_EXP},
    '{ROW_REG, REG_WIN2_LIMIT, CMD_READ, SZ_BYTE, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD, 32'h0000_1000, 32'h0123_4567, 1'b0, NO_EXP},
    '{ROW_ACCESS, REG_WIN0_BASE, CMD_WRITE, SZ_WORD_ALIAS, 32'h0000_3003, 32'hFFFF_FFFF, 1'b0,
      NO_EXP}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [1:0]           in_access_size;
  logic [31:0]          in_bus_address;
  logic [31:0]          in_write_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WIN_IDX_W-1:0] out_window_index;
  logic [31:0]          out_offset;
  logic [1:0]           out_sub_size;
  logic [1:0]           out_byte_lane;
  logic [31:0]          out_sub_write_data;
  logic                 out_is_write;
  logic                 out_unmapped;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  sub_access_t pending_subs[$];
  logic [31:0] window_first [MAX_WINDOWS];
  logic [31:0] window_last [MAX_WINDOWS];
  logic [31:0] addr_region;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  bit          long_hold = 1'b0;
  int          hold_count = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bus_window_decoder_with_splitting u_dut (.*);

  function automatic void enqueue_sub(input sub_access_t s);
    pending_subs = {pending_subs, s};
  endfunction

  function automatic string describe(input sub_access_t s);
    return $sformatf("win %0d off %h size %0d lane %0d data %h wr %b unm %b last %b",
                     s.win, s.offset, s.size, s.lane, s.wdata, s.wr, s.unm, s.last);
  endfunction

  // Lowest base wins; a strict compare keeps the lower index on equal bases.
  function automatic int find_window(input logic [31:0] lo, input logic [31:0] hi);
    int best;
    int w;
    best = -1;
    for (w = 0; w < NUM_WINDOWS; w++) begin
      if (lo >= window_first[w] && lo <= window_last[w] &&
          hi >= window_first[w] && hi <= window_last[w]) begin
        if (best < 0 || window_first[w] < window_first[best]) best = w;
      end
    end
    return best;
  endfunction

  // Queues one sub-access if a window holds the range, or if the range is a
  // single byte (then flagged unmapped). Returns 0 when the range must split.
  function automatic bit serve_range(input logic [31:0] a, input logic [1:0] sz,
                                     input logic [31:0] d, input logic [1:0] lane,
                                     input logic wr);
    int          w;
    sub_access_t s;
    w = find_window(a, a + ((32'd1 << sz) - 32'd1));
    s = '0;
    s.size = sz;
    s.lane = lane;
    s.wr = wr;
    if (w >= 0) begin
      s.win = w[WIN_IDX_W-1:0];
      s.offset = a - window_first[w];
    end else if (sz == SZ_BYTE) begin
      s.unm = 1'b1;
    end else begin
      return 1'b0;
    end
    s.wdata = wr ? d : 32'd0;
    enqueue_sub(s);
    return 1'b1;
  endfunction

  function automatic void serve_halfword(input logic [31:0] a, input logic [31:0] d,
                                         input logic [1:0] lane, input logic wr);
    if (!serve_range(a, SZ_HALF, d, lane, wr)) begin
      void'(serve_range(a, SZ_BYTE, {24'b0, d[7:0]}, lane, wr));
      void'(serve_range(a + 32'd1, SZ_BYTE, {24'b0, d[15:8]}, lane + 2'd1, wr));
    end
  endfunction

  function automatic void predict_access(input logic cmd, input logic [1:0] size,
                                         input logic [31:0] addr, input logic [31:0] data);
    logic [1:0]  sz;
    logic [31:0] a;
    logic [31:0] d;
    sub_access_t tail;
    sz = (size == SZ_WORD_ALIAS) ? SZ_WORD : size;
    a = addr;
    d = data;
    if (sz == SZ_WORD) begin
      a[1:0] = 2'b00;
    end else if (sz == SZ_HALF) begin
      a[0] = 1'b0;
      d[31:16] = '0;
    end else begin
      d[31:8] = '0;
    end
    if (!serve_range(a, sz, d, 2'd0, cmd)) begin
      if (sz == SZ_HALF) begin
        serve_halfword(a, d, 2'd0, cmd);
      end else begin
        serve_halfword(a, {16'b0, d[15:0]}, 2'd0, cmd);
        serve_halfword(a + 32'd2, {16'b0, d[31:16]}, 2'd2, cmd);
      end
    end
    tail = pending_subs.pop_back();
    tail.last = 1'b1;
    enqueue_sub(tail);
  endfunction

  // Called at a falling edge; leaves cfg_valid high so that back-to-back
  // writes need no gap. The caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx[0] == CFG_SEL_LIMIT) window_last[idx[CFG_IDX_W-1:1]] = val;
    else window_first[idx[CFG_IDX_W-1:1]] = val;
    @(negedge clk);
  endtask

  task automatic send_access(input logic cmd, input logic [1:0] size,
                             input logic [31:0] addr, input logic [31:0] data,
                             input logic typed, input sub_access_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd = cmd;
    in_access_size = size;
    in_bus_address = addr;
    in_write_data = data;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (typed) enqueue_sub(want);
    else predict_access(cmd, size, addr, data);
    @(negedge clk);
  endtask

  // Each access yields at least one beat, so an empty store plus the
  // worst-case decode time means the block is idle.
  task automatic wait_drained();
    while (pending_subs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_windows(input int phase);
    logic [31:0] lo;
    logic [31:0] hi;
    int          w;
    if (phase == 0) begin
      addr_region = '0;
      write_reg(REG_WIN0_BASE, 32'h0000_0000);
      write_reg(REG_WIN0_LIMIT, 32'hFFFF_FFFF);
      write_reg(REG_WIN1_BASE, 32'hFFFF_FFFF);
      write_reg(REG_WIN1_LIMIT, 32'hFFFF_FFFF);
      write_reg(REG_WIN2_BASE, 32'h0000_0000);
      write_reg(REG_WIN2_LIMIT, 32'h0000_0000);
      write_reg(REG_WIN3_BASE, 32'hFFFF_FFFF);
      write_reg(REG_WIN3_LIMIT, 32'h0000_0000);
    end else begin
      if (phase == 1) addr_region = 32'hFFFF_FF00;
      else if (phase == 2) addr_region = '0;
      else addr_region = $urandom & 32'hFFFF_FF00;
      // Small windows packed into one region so that most accesses split.
      for (w = 0; w < NUM_WINDOWS; w++) begin
        lo = addr_region + $urandom_range(0, 95);
        if ($urandom_range(0, 5) == 0) hi = lo - $urandom_range(1, 8);
        else hi = lo + $urandom_range(0, 23);
        write_reg({w[1:0], CFG_SEL_BASE}, lo);
        write_reg({w[1:0], CFG_SEL_LIMIT}, hi);
      end
    end
  endtask

  always @(negedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      out_ready = 1'b0;
      hold_count++;
    end else begin
      if (!long_hold) hold_count = 0;
      out_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : check_beats
    sub_access_t got;
    sub_access_t want;
    if (rst_n && out_valid && out_ready) begin
      got.win = out_window_index;
      got.offset = out_offset;
      got.size = out_sub_size;
      got.lane = out_byte_lane;
      got.wdata = out_sub_write_data;
      got.wr = out_is_write;
      got.unm = out_unmapped;
      got.last = out_last;
      if (pending_subs.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected beat: %s", describe(got));
        mismatch_count++;
      end else begin
        want = pending_subs.pop_front();
        if (got.win !== want.win || got.offset !== want.offset || got.size !== want.size ||
            got.lane !== want.lane || got.wdata !== want.wdata || got.wr !== want.wr ||
            got.unm !== want.unm || got.last !== want.last) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("mismatch: expected %s", describe(want));
            $display("          got      %s", describe(got));
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("bus_window_decoder_with_splitting regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    logic [31:0] addr;
    int          i;
    int          p;
    int          n;
    int          r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_READ;
    in_access_size = SZ_BYTE;
    in_bus_address = '0;
    in_write_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WIN0_BASE;
    cfg_data = '0;
    addr_region = '0;
    for (i = 0; i < MAX_WINDOWS; i++) begin
      window_first[i] = '0;
      window_last[i] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_REG) begin
        if (i > 0 && DIRECTED[i-1].kind == ROW_ACCESS) begin
          in_valid = 1'b0;
          wait_drained();
        end
        write_reg(row.idx, row.data);
      end else begin
        cfg_valid = 1'b0;
        send_access(row.cmd, row.size, row.addr, row.data, row.typed, row.want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      in_valid = 1'b0;
      long_hold = 1'b0;
      wait_drained();
      program_windows(p);
      cfg_valid = 1'b0;
      case (pace_t'(p % 4))
        PACE_FULL: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        PACE_SENDER_IDLE: begin
          sender_idle_pct = 79;
          receiver_stall_pct = 0;
        end
        PACE_RECEIVER_STALL: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 79;
        end
        default: begin
          sender_idle_pct = 37;
          receiver_stall_pct = 37;
        end
      endcase
      // One full-rate phase opens with a long receiver hold-off so the
      // result side backs up into the input.
      long_hold = (p == 4);
      for (n = 0; n < ACCESSES_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80) addr = addr_region + $urandom_range(0, 127);
        else if (r < 90) addr = addr_region - $urandom_range(1, 16);
        else addr = $urandom;
        send_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), addr, $urandom,
                    1'b0, NO_EXP);
      end
    end

    in_valid = 1'b0;
    long_hold = 1'b0;
    wait_drained();
    if (mismatch_count == 0 && pending_subs.size() == 0)
      $display("bus_window_decoder_with_splitting regression: pass");
    else
      $display("bus_window_decoder_with_splitting regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bwd_pkg.sv
rtl/bwd_ctrl.sv
rtl/bwd_dp.sv
rtl/bus_window_decoder_with_splitting.sv
sim/tb_top.sv
